[src/sobel_pkg.sv]
// Shared types and constants of the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_pkg;

  localparam int unsigned CmdColW       = 13;
  localparam int unsigned CmdQueueDepth = 2;

  typedef enum logic [1:0] {
    RegImageWidth  = 2'd0,
    RegImageHeight = 2'd1,
    RegMaxValue    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        frame_start;
  } in_t;

  typedef struct packed {
    logic [15:0] edge_value;
    logic [15:0] out_row;
    logic [10:0] out_col;
    logic        frame_last;
  } out_t;

  typedef struct packed {
    logic [15:0]        pix;
    logic [CmdColW-1:0] col;
    logic               emit;
    logic               last;
    logic [15:0]        out_row;
    logic [10:0]        out_col;
  } cmd_t;

endpackage

[src/sobel_fifo.sv]
// Small register queue between the front and back parts.
`timescale 1ns / 1ps

module sobel_fifo #(
  parameter int unsigned Depth = 2,
  parameter type item_t = logic
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t            mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

[src/sobel_front.sv]
// Front part: raster position tracking and interior classification.
`timescale 1ns / 1ps

module sobel_front #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  sobel_pkg::in_t    item_i,
  input  logic [11:0]       image_width_i,
  input  logic [15:0]       image_height_i,
  output sobel_pkg::cmd_t   cmd_o
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned DimW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;

  logic [ColW-1:0] col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [DimW-1:0] w_raw, w_eff, c0, c1, cn, col_m1;
  logic [15:0]     h_eff, r0, r2, row_m1;
  logic [16:0]     r0p1, r1, rn;

  always_comb begin
    w_raw = DimW'(image_width_i);
    if (w_raw < DimW'(3)) begin
      w_eff = DimW'(3);
    end else if (w_raw > DimW'(MAX_WIDTH)) begin
      w_eff = DimW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    h_eff = (image_height_i < 16'd3) ? 16'd3 : image_height_i;

    c0   = item_i.frame_start ? '0 : DimW'(col_q);
    r0   = item_i.frame_start ? '0 : row_q;
    r0p1 = {1'b0, r0} + 17'd1;
    if (c0 >= w_eff) begin
      c1 = '0;
      r1 = r0p1;
    end else begin
      c1 = c0;
      r1 = {1'b0, r0};
    end
    r2     = (r1 >= {1'b0, h_eff}) ? '0 : r1[15:0];
    row_m1 = r2 - 16'd1;
    col_m1 = c1 - DimW'(1);

    cmd_o                 = '0;
    cmd_o.pix             = 16'(item_i.pixel_value[PIXEL_BITS-1:0]);
    cmd_o.col[ColW-1:0]   = c1[ColW-1:0];
    cmd_o.emit            = (r2 >= 16'd2) && (c1 >= DimW'(2));
    cmd_o.last            = (r2 == h_eff - 16'd1) && (c1 == w_eff - DimW'(1));
    cmd_o.out_row         = row_m1;
    cmd_o.out_col         = col_m1[10:0];

    cn = c1 + DimW'(1);
    rn = {1'b0, r2} + 17'd1;
    if (cn >= w_eff) begin
      col_d = '0;
      row_d = (rn >= {1'b0, h_eff}) ? '0 : rn[15:0];
    end else begin
      col_d = cn[ColW-1:0];
      row_d = r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[src/sobel_back.sv]
// Back part: line stores, 3x3 window, gradients and threshold.
`timescale 1ns / 1ps

module sobel_back #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [15:0]      max_value_i,
  input  logic             cmd_valid_i,
  input  sobel_pkg::cmd_t  cmd_i,
  output logic             cmd_pop_o,
  output logic             out_valid_o,
  output sobel_pkg::out_t  out_item_o,
  input  logic             out_pop_i
);

  localparam int unsigned ColW = $clog2(MAX_WIDTH);
  localparam int unsigned P    = PIXEL_BITS;
  localparam int unsigned SumW = P + 2;
  localparam int unsigned GradW = P + 3;
  localparam int unsigned CmpW = (GradW > 16) ? GradW : 16;

  logic [P-1:0] upper_mem [MAX_WIDTH];
  logic [P-1:0] middle_mem [MAX_WIDTH];
  logic [P-1:0] up_rd_q, mid_rd_q;
  logic [P-1:0] byp_top_q, byp_mid_q;
  logic         byp_q;
  logic [P-1:0] win_q [6];

  logic            a_valid_q, b_valid_q, c_valid_q;
  sobel_pkg::cmd_t a_cmd_q;
  logic signed [GradW-1:0] b_gx_q, b_gy_q;
  logic [15:0]     b_row_q;
  logic [10:0]     b_col_q;
  logic            b_last_q;
  sobel_pkg::out_t c_item_q;

  logic a_load, a_fire, a_ready, b_fire, b_ready, c_ready;
  logic [ColW-1:0] rd_addr, wr_addr;
  logic [P-1:0]    top_val, mid_val, pix_val;
  logic [SumW-1:0] pos_x, neg_x, pos_y, neg_y;
  logic signed [GradW-1:0] gx, gy, gx_neg, gy_neg;
  logic [SumW-1:0] ax, ay;
  logic [GradW-1:0] mag_sum;
  logic            over;

  assign c_ready = !c_valid_q || out_pop_i;
  assign b_fire  = b_valid_q && c_ready;
  assign b_ready = !b_valid_q || c_ready;
  assign a_fire  = a_valid_q && b_ready;
  assign a_ready = !a_valid_q || b_ready;
  assign a_load  = cmd_valid_i && a_ready;
  assign cmd_pop_o = a_load;

  assign rd_addr = cmd_i.col[ColW-1:0];
  assign wr_addr = a_cmd_q.col[ColW-1:0];
  assign pix_val = a_cmd_q.pix[P-1:0];
  assign top_val = byp_q ? byp_top_q : up_rd_q;
  assign mid_val = byp_q ? byp_mid_q : mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      up_rd_q <= upper_mem[rd_addr];
    end
    if (a_fire) begin
      upper_mem[wr_addr] <= mid_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      mid_rd_q <= middle_mem[rd_addr];
    end
    if (a_fire) begin
      middle_mem[wr_addr] <= pix_val;
    end
  end

  always_comb begin
    pos_x  = SumW'(pix_val) + SumW'({mid_val, 1'b0}) + SumW'(top_val);
    neg_x  = SumW'(win_q[2]) + SumW'({win_q[1], 1'b0}) + SumW'(win_q[0]);
    pos_y  = SumW'(pix_val) + SumW'({win_q[5], 1'b0}) + SumW'(win_q[2]);
    neg_y  = SumW'(top_val) + SumW'({win_q[3], 1'b0}) + SumW'(win_q[0]);
    gx     = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
    gy     = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
    gx_neg = -b_gx_q;
    gy_neg = -b_gy_q;
    ax      = b_gx_q[GradW-1] ? gx_neg[SumW-1:0] : b_gx_q[SumW-1:0];
    ay      = b_gy_q[GradW-1] ? gy_neg[SumW-1:0] : b_gy_q[SumW-1:0];
    mag_sum = {1'b0, ax} + {1'b0, ay};
    over    = CmpW'(mag_sum) > CmpW'(max_value_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      byp_q     <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else begin
      if (a_load) begin
        a_valid_q <= 1'b1;
        byp_q     <= a_fire && (a_cmd_q.col == cmd_i.col);
      end else if (a_fire) begin
        a_valid_q <= 1'b0;
      end
      if (a_fire) begin
        b_valid_q <= a_cmd_q.emit;
        win_q[0]  <= win_q[3];
        win_q[1]  <= win_q[4];
        win_q[2]  <= win_q[5];
        win_q[3]  <= top_val;
        win_q[4]  <= mid_val;
        win_q[5]  <= pix_val;
      end else if (b_fire) begin
        b_valid_q <= 1'b0;
      end
      if (b_fire) begin
        c_valid_q <= 1'b1;
      end else if (out_pop_i) begin
        c_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_load) begin
      a_cmd_q   <= cmd_i;
      byp_top_q <= mid_val;
      byp_mid_q <= pix_val;
    end
    if (a_fire) begin
      b_gx_q   <= gx;
      b_gy_q   <= gy;
      b_row_q  <= a_cmd_q.out_row;
      b_col_q  <= a_cmd_q.out_col;
      b_last_q <= a_cmd_q.last;
    end
    if (b_fire) begin
      c_item_q.edge_value <= over ? max_value_i : 16'd0;
      c_item_q.out_row    <= b_row_q;
      c_item_q.out_col    <= b_col_q;
      c_item_q.frame_last <= b_last_q;
    end
  end

  assign out_valid_o = c_valid_q;
  assign out_item_o  = c_item_q;

endmodule

[src/sobel_edge_threshold_top.sv]
// Top level of the Sobel 3x3 edge detector with threshold.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------------
//  pixels    | in        | push / full          | in_item_i  (pixel_value, frame_start)
//  results   | out       | pop / empty          | out_item_o (edge_value, row, col, last)
//  registers | in        | APB psel/penable     | paddr, pwdata, prdata
//
//  One pixel per cycle sustained while the result port does not stall; a result goes
//  through the command queue, line store read, gradient, magnitude and threshold stages.
//  Border pixels pass through the line stores and window but give no result.
//  A stalled result port backs up the back part and then the queue; push is refused
//  only once the queue is full. Reset clears counters, window and valid flags;
//  the line stores hold no reset value.
`timescale 1ns / 1ps

module sobel_edge_threshold_top #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  sobel_pkg::in_t   in_item_i,
  output logic             empty,
  input  logic             pop,
  output sobel_pkg::out_t  out_item_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [11:0] image_width_q;
  logic [15:0] image_height_q;
  logic [15:0] max_value_q;
  logic        cfg_wr;
  logic        accept;
  logic        cmd_valid, cmd_pop, out_valid;
  sobel_pkg::cmd_t cmd_in, cmd_out;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 12'd256;
      image_height_q <= 16'd256;
      max_value_q    <= 16'd255;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        sobel_pkg::RegImageWidth:  image_width_q  <= pwdata[11:0];
        sobel_pkg::RegImageHeight: image_height_q <= pwdata[15:0];
        sobel_pkg::RegMaxValue:    max_value_q    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sobel_pkg::RegImageWidth:  prdata = 32'(image_width_q);
      sobel_pkg::RegImageHeight: prdata = 32'(image_height_q);
      sobel_pkg::RegMaxValue:    prdata = 32'(max_value_q);
      default:                   prdata = '0;
    endcase
  end

  assign accept = push && !full;

  sobel_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .item_i        (in_item_i),
    .image_width_i (image_width_q),
    .image_height_i(image_height_q),
    .cmd_o         (cmd_in)
  );

  sobel_fifo #(
    .Depth (sobel_pkg::CmdQueueDepth),
    .item_t(sobel_pkg::cmd_t)
  ) u_cmd_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .item_i (cmd_in),
    .full_o (full),
    .pop_i  (cmd_pop),
    .valid_o(cmd_valid),
    .item_o (cmd_out)
  );

  sobel_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .max_value_i(max_value_q),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .out_valid_o(out_valid),
    .out_item_o (out_item_o),
    .out_pop_i  (pop)
  );

  assign empty = !out_valid;

`ifndef SYNTHESIS
  a_edge_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.edge_value == 16'd0 || out_item_o.edge_value == max_value_q))
    else $error("edge value is neither zero nor the max value");

  a_interior_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.out_row != 16'd0)
    else $error("result on the top border row");

  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("back part took a command from an empty queue");
`endif

endmodule
